### sv/pale_pkg.sv
`timescale 1ns / 1ps

package pale_pkg;

  // Default list capacity
  localparam int DEPTH_DEF = 32;

  // Fixed field widths
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 6;

  // Request kinds as they arrive on the input
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_SEARCH = 3'd3,
    KIND_INSERT = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  // Decoded operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_DELETE,
    OP_SEARCH,
    OP_INSERT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DELETE,
    S_INSERT
  } state_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [POS_W-1:0]        found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      count;
  } out_t;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // Classify a raw kind code; unused codes become a no-op
  function automatic op_t decode_kind(logic [2:0] kind);
    op_t op;
    unique case (kind)
      KIND_CLEAR:  op = OP_CLEAR;
      KIND_APPEND: op = OP_APPEND;
      KIND_DELETE: op = OP_DELETE;
      KIND_SEARCH: op = OP_SEARCH;
      KIND_INSERT: op = OP_INSERT;
      KIND_READ:   op = OP_READ;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

### sv/pale_front.sv
`timescale 1ns / 1ps

module pale_front
  import pale_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  // Two-entry command queue between decode and execution
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;
  cmd_t       dec;

  assign full      = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Classify the incoming request
  always_comb begin
    dec.op    = decode_kind(in_data.kind);
    dec.pos   = in_data.position;
    dec.value = in_data.value;
  end

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### sv/pale_back.sv
`timescale 1ns / 1ps

module pale_back
  import pale_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // List storage: one write and one registered read per cycle
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic signed [VAL_W-1:0] wdata;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  cmd_t           cur_r, cur_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  pend_idx_r, pend_idx_nxt;
  logic           pend_r, pend_nxt;
  logic           iss_r, iss_nxt;
  logic           out_vld_r, out_vld_nxt;
  out_t           res_r, res_nxt;

  logic           slot_free;
  logic           list_full;
  logic           bad_pos;
  logic [PW-1:0]  cmd_pos_w, cur_pos_w;

  assign empty     = !out_vld_r;
  assign out_data  = res_r;
  assign slot_free = !out_vld_r || pop;
  assign list_full = (cnt_r == CW'(DEPTH));
  assign cmd_pos_w = PW'(cmd.pos);
  assign cur_pos_w = PW'(cur_r.pos);
  assign bad_pos   = (cmd_pos_w >= PW'(cnt_r));

  // Sequencer: next state, memory control and result
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    iss_nxt      = iss_r;
    out_vld_nxt  = out_vld_r && !pop;
    res_nxt      = res_r;
    cmd_take     = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take            = 1'b1;
          cur_nxt             = cmd;
          pend_nxt            = 1'b0;
          res_nxt.status      = ST_OK;
          res_nxt.found_index = '0;
          res_nxt.read_value  = '0;
          res_nxt.count       = COUNT_W'(cnt_r);
          unique case (cmd.op)
            OP_CLEAR: begin
              cnt_nxt       = '0;
              res_nxt.count = '0;
              out_vld_nxt   = 1'b1;
            end
            OP_APPEND: begin
              if (list_full) begin
                res_nxt.status = ST_FULL;
              end else begin
                we            = 1'b1;
                waddr         = AW'(cnt_r);
                wdata         = cmd.value;
                cnt_nxt       = cnt_r + CW'(1);
                res_nxt.count = COUNT_W'(cnt_r + CW'(1));
              end
              out_vld_nxt = 1'b1;
            end
            OP_READ: begin
              if (bad_pos) begin
                res_nxt.status = ST_BADPOS;
                out_vld_nxt    = 1'b1;
              end else begin
                raddr     = AW'(cmd.pos);
                state_nxt = S_READ;
              end
            end
            OP_SEARCH: begin
              idx_nxt   = '0;
              state_nxt = S_SEARCH;
            end
            OP_DELETE: begin
              if (bad_pos) begin
                res_nxt.status = ST_BADPOS;
                out_vld_nxt    = 1'b1;
              end else begin
                idx_nxt   = CW'(cmd.pos) + CW'(1);
                state_nxt = S_DELETE;
              end
            end
            OP_INSERT: begin
              if (bad_pos) begin
                res_nxt.status = ST_BADPOS;
                out_vld_nxt    = 1'b1;
              end else if (list_full) begin
                res_nxt.status = ST_FULL;
                out_vld_nxt    = 1'b1;
              end else begin
                idx_nxt   = cnt_r - CW'(1);
                iss_nxt   = 1'b1;
                state_nxt = S_INSERT;
              end
            end
            default: begin
              out_vld_nxt = 1'b1;
            end
          endcase
        end
      end

      // Read data arrives in the cycle after the address
      S_READ: begin
        res_nxt.read_value = rdata_r;
        out_vld_nxt        = 1'b1;
        state_nxt          = S_IDLE;
      end

      // Walk up from entry zero, compare in the cycle after each read
      S_SEARCH: begin
        if (pend_r && (rdata_r == cur_r.value)) begin
          res_nxt.found_index = POS_W'(pend_idx_r);
          out_vld_nxt         = 1'b1;
          state_nxt           = S_IDLE;
        end else if (idx_r < cnt_r) begin
          raddr        = AW'(idx_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + CW'(1);
        end else begin
          res_nxt.status = ST_NOTFOUND;
          out_vld_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // Close the gap: entry k moves down to k-1
      S_DELETE: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = AW'(pend_idx_r - CW'(1));
          wdata = rdata_r;
        end
        if (idx_r < cnt_r) begin
          raddr        = AW'(idx_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + CW'(1);
        end else begin
          cnt_nxt       = cnt_r - CW'(1);
          res_nxt.count = COUNT_W'(cnt_r - CW'(1));
          out_vld_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Open a gap from the top down, then drop the new value in
      S_INSERT: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = AW'(pend_idx_r + CW'(1));
          wdata = rdata_r;
        end
        if (iss_r) begin
          raddr        = AW'(idx_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          if (PW'(idx_r) == cur_pos_w) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - CW'(1);
          end
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          we            = 1'b1;
          waddr         = AW'(cur_r.pos);
          wdata         = cur_r.value;
          cnt_nxt       = cnt_r + CW'(1);
          res_nxt.count = COUNT_W'(cnt_r + CW'(1));
          out_vld_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      iss_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      iss_r     <= iss_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
  end

  // List memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_slot_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_vld_r)
    else $error("result slot busy while a request is in progress");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (state_r == S_IDLE) && slot_free)
    else $error("request taken while busy");

  a_ins_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT && iss_r) |-> (PW'(idx_r) >= cur_pos_w))
    else $error("insert shift walked below target position");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_nxt == S_IDLE) |->
      (cnt_nxt == cnt_r || cnt_nxt == cnt_r + CW'(1) || cnt_nxt == cnt_r - CW'(1)))
    else $error("entry count jumped on a shift operation");

endmodule

### sv/positional_array_list_engine_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                      Handshake
// input     push, full, in_data        taken when push && !full
// result    empty, pop, out_data       taken when pop && !empty
//
// Clear, append and no-op finish straight from idle; a read passes through S_READ.
// Search walks up from entry zero to a match or the end; delete moves entries down;
// insert moves entries up from the top. The walk covers one entry per cycle.
// A two-entry request queue keeps input flowing while the executor works.
// rst_n is synchronous: count and queues clear, list contents are kept.
// A result not popped holds the executor before its next request.

module positional_array_list_engine_unit
  import pale_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  pale_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  pale_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
